// ===== design/des_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int REQ_W           = 4;
    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int TOTAL_W         = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_DOWN = 4'd0,
        REQ_PUSH_TOP  = 4'd1,
        REQ_POP_DOWN  = 4'd2,
        REQ_POP_TOP   = 4'd3,
        REQ_PEEK_DOWN = 4'd4,
        REQ_PEEK_TOP  = 4'd5,
        REQ_WALK_DOWN = 4'd6,
        REQ_WALK_TOP  = 4'd7,
        REQ_CLEAR     = 4'd8
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_WALK
    } t_state;

    typedef enum logic [1:0] {
        RD_DOWN_HEAD,
        RD_TOP_HEAD,
        RD_WALK
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    push_down;
        logic    push_top;
        logic    pop_down;
        logic    pop_top;
        logic    clear;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    walk_start;
        logic    walk_top;
        logic    walk_step;
        logic    emit;
        t_status emit_status;
        logic    emit_data;
        logic    emit_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_req req;
        logic down_empty;
        logic top_empty;
        logic full;
        logic walk_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/des_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module des_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire des_pkg::t_dp_stat i_stat,
    output des_pkg::t_dp_cmd       o_cmd
);
    import des_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel      = RD_WALK;
        o_cmd.emit_status = ST_OK;
        busy    = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state        = S_IDLE;
                o_cmd.emit     = 1'b1;
                o_cmd.emit_last = 1'b1;
                unique case (i_stat.req)
                    REQ_PUSH_DOWN, REQ_PUSH_TOP: begin
                        if (i_stat.full) begin
                            o_cmd.emit_status = ST_FULL;
                        end else begin
                            o_cmd.push_down = (i_stat.req == REQ_PUSH_DOWN);
                            o_cmd.push_top  = (i_stat.req == REQ_PUSH_TOP);
                        end
                    end
                    REQ_POP_DOWN, REQ_PEEK_DOWN: begin
                        if (i_stat.down_empty) begin
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.emit   = 1'b0;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_DOWN_HEAD;
                            n_state      = S_READ;
                        end
                    end
                    REQ_POP_TOP, REQ_PEEK_TOP: begin
                        if (i_stat.top_empty) begin
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.emit   = 1'b0;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP_HEAD;
                            n_state      = S_READ;
                        end
                    end
                    REQ_WALK_DOWN: begin
                        if (i_stat.down_empty) begin
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.emit       = 1'b0;
                            o_cmd.rd_en      = 1'b1;
                            o_cmd.rd_sel     = RD_DOWN_HEAD;
                            o_cmd.walk_start = 1'b1;
                            n_state          = S_WALK;
                        end
                    end
                    REQ_WALK_TOP: begin
                        if (i_stat.top_empty) begin
                            o_cmd.emit_status = ST_EMPTY;
                        end else begin
                            o_cmd.emit       = 1'b0;
                            o_cmd.rd_en      = 1'b1;
                            o_cmd.rd_sel     = RD_TOP_HEAD;
                            o_cmd.walk_start = 1'b1;
                            o_cmd.walk_top   = 1'b1;
                            n_state          = S_WALK;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.clear = 1'b1;
                    end
                    default: begin
                        // unused codes give a plain ok result
                    end
                endcase
            end
            S_READ: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_data = 1'b1;
                o_cmd.emit_last = 1'b1;
                o_cmd.pop_down  = (i_stat.req == REQ_POP_DOWN);
                o_cmd.pop_top   = (i_stat.req == REQ_POP_TOP);
                n_state         = S_IDLE;
            end
            S_WALK: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_data = 1'b1;
                o_cmd.emit_last = i_stat.walk_last;
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end else begin
                    // fetch the next entry while this one goes out
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = RD_WALK;
                    o_cmd.walk_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/des_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module des_dpath #(
    parameter int DEPTH       = des_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = des_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [des_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [des_pkg::DATA_W-1:0]    i_data_in,
    input  wire des_pkg::t_dp_cmd              i_cmd,
    output des_pkg::t_dp_stat                  o_stat,
    output logic                               o_valid,
    output logic [des_pkg::DATA_W-1:0]         o_data_out,
    output logic [des_pkg::STATUS_W-1:0]       o_status,
    output logic [des_pkg::TOTAL_W-1:0]        o_total_count,
    output logic                               o_last_result
);
    import des_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [ENTRY_WIDTH-1:0] r_mem [DEPTH];

    t_req                   r_req;
    logic [DATA_W-1:0]      r_data;
    logic [CW-1:0]          r_down_cnt;
    logic [CW-1:0]          r_top_cnt;
    logic [AW-1:0]          r_ptr;
    logic                   r_walk_top;
    logic [CW-1:0]          r_remain;
    logic [ENTRY_WIDTH-1:0] r_rd_data;
    logic                   r_valid;
    logic [DATA_W-1:0]      r_data_out;
    t_status                r_status;
    logic                   r_last;

    logic [CW-1:0]          w_total;
    logic [AW-1:0]          w_down_head;
    logic [AW-1:0]          w_top_head;
    logic [AW-1:0]          w_wr_addr;
    logic [AW-1:0]          w_rd_addr;
    logic [CW-1:0]          w_top_head_c;
    logic [CW-1:0]          w_top_free_c;
    logic [CW-1:0]          w_down_head_c;

    assign w_total       = r_down_cnt + r_top_cnt;
    assign w_down_head_c = r_down_cnt - CW'(1);
    assign w_top_head_c  = CW'(DEPTH) - r_top_cnt;
    assign w_top_free_c  = CW'(DEPTH - 1) - r_top_cnt;
    assign w_down_head   = w_down_head_c[AW-1:0];
    assign w_top_head    = w_top_head_c[AW-1:0];
    assign w_wr_addr     = i_cmd.push_down ? r_down_cnt[AW-1:0] : w_top_free_c[AW-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_DOWN_HEAD: w_rd_addr = w_down_head;
            RD_TOP_HEAD:  w_rd_addr = w_top_head;
            default:      w_rd_addr = r_ptr;
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= t_req'(i_req_type);
            r_data <= i_data_in;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_down || i_cmd.push_top) begin
            r_mem[w_wr_addr] <= ENTRY_WIDTH'(r_data);
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_cnt <= '0;
            r_top_cnt  <= '0;
        end else if (i_cmd.clear) begin
            r_down_cnt <= '0;
            r_top_cnt  <= '0;
        end else begin
            if (i_cmd.push_down) begin
                r_down_cnt <= r_down_cnt + CW'(1);
            end else if (i_cmd.pop_down) begin
                r_down_cnt <= r_down_cnt - CW'(1);
            end
            if (i_cmd.push_top) begin
                r_top_cnt <= r_top_cnt + CW'(1);
            end else if (i_cmd.pop_top) begin
                r_top_cnt <= r_top_cnt - CW'(1);
            end
        end
    end

    // walk pointer runs from the head towards the bottom of the chosen stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_walk_top <= i_cmd.walk_top;
            if (i_cmd.walk_top) begin
                r_ptr    <= w_top_head + AW'(1);
                r_remain <= r_top_cnt;
            end else begin
                r_ptr    <= w_down_head - AW'(1);
                r_remain <= r_down_cnt;
            end
        end else if (i_cmd.walk_step) begin
            r_ptr    <= r_walk_top ? r_ptr + AW'(1) : r_ptr - AW'(1);
            r_remain <= r_remain - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_data_out <= i_cmd.emit_data ? DATA_W'(r_rd_data) : '0;
            r_status   <= i_cmd.emit_status;
            r_last     <= i_cmd.emit_last;
        end
    end

    assign o_stat.req        = r_req;
    assign o_stat.down_empty = (r_down_cnt == '0);
    assign o_stat.top_empty  = (r_top_cnt == '0);
    assign o_stat.full       = (w_total >= CW'(DEPTH));
    assign o_stat.walk_last  = (r_remain == CW'(1));

    assign o_valid       = r_valid;
    assign o_data_out    = r_data_out;
    assign o_status      = r_status;
    assign o_total_count = TOTAL_W'(w_total);
    assign o_last_result = r_last;

endmodule

`default_nettype wire

// ===== design/double_ended_stack_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// push, clear, ignored codes and error results: strobe registered from the execute state after the transfer
// pop and peek: one store read in the execute state, then the strobe registered from the read state
// walk of n entries: n strobes on consecutive cycles from the walk state, one store read each
// busy is low again in the cycle of the last strobe; results cannot be stalled
// synchronous active-low reset empties both stacks; store contents are not cleared

module double_ended_stack_engine #(
    parameter int DEPTH       = des_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = des_pkg::ENTRY_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [des_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic [des_pkg::DATA_W-1:0]    i_data_in,
    output logic                               o_valid,
    output logic [des_pkg::DATA_W-1:0]         o_data_out,
    output logic [des_pkg::STATUS_W-1:0]       o_status,
    output logic [des_pkg::TOTAL_W-1:0]        o_total_count,
    output logic                               o_last_result
);
    import des_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    des_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    des_dpath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req_type),
        .i_data_in     (i_data_in),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .o_data_out    (o_data_out),
        .o_status      (o_status),
        .o_total_count (o_total_count),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire
